@@ hdl/mhte_pkg.sv @@
`timescale 1ns / 1ps

package mhte_pkg;

   // fixed field widths of the request and response beats
   localparam int KEY_W    = 31;
   localparam int SLOT_W   = 7;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 3;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INS_HOME   = 3'd0,
      REQ_INS_LINEAR = 3'd1,
      REQ_INS_QUAD   = 3'd2,
      REQ_SEARCH     = 3'd3,
      REQ_DELETE     = 3'd4
   } req_code_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_LOOK,
      S_CHECK,
      S_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       mod_step;
      logic       probe_start;
      logic       probe_adv;
      logic       clear_step;
      logic       rd_sel_next;
      logic       wr_en;
      logic       wr_key;
      logic       res_set;
      logic       res_use_idx;
      status_type res_status;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic             mod_last;
      logic             key_nz;
      logic             slot_empty;
      logic             slot_match;
      logic             probe_last;
      logic             clear_last;
      logic             rsp_blocked;
      logic [REQ_W-1:0] req_code;
   } sts_type;

endpackage

@@ hdl/modulo_hash_table_engine_top.sv @@
`timescale 1ns / 1ps

// channel | direction | beat fields
// req_    | in        | req_type (3), req_key (31)
// rsp_    | out       | rsp_status (2), rsp_slot (7)
//
// one request at a time; the home slot comes from a reciprocal multiply for the
// quotient, then a multiply back and subtract; then slots are examined one per cycle
// through the registered read port of the key memory: k slots per beat, k = 1 for
// home insert, search and delete, 1 to TABLE_SIZE for probing inserts.
// after reset the key memory is zeroed one slot per cycle, with req_stall high
// throughout. a stalled response holds; the next request is taken
// while it waits and finishes into the response register once it drains.

module modulo_hash_table_engine_top #(
   parameter int TABLE_SIZE = 101
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mhte_pkg::REQ_W-1:0]      req_type,
   input  logic [mhte_pkg::KEY_W-1:0]      req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mhte_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mhte_pkg::SLOT_W-1:0]     rsp_slot
);

   import mhte_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller
   mhte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   mhte_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_type   (req_type),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

endmodule

@@ hdl/mhte_ram.sv @@
`timescale 1ns / 1ps

module mhte_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 101
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mhte_ctrl.sv @@
`timescale 1ns / 1ps

module mhte_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhte_pkg::sts_type sts,
   output mhte_pkg::cmd_type cmd
);

   import mhte_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   req_code_type code;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      code     = req_code_type'(sts.req_code);
      state_in = state_ff;
      cmd      = '0;
      cmd.res_status = ST_MISS;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one slot per cycle
            cmd.wr_en      = 1'b1;
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HOME;
            end
         end

         S_HOME: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            // read the home slot
            cmd.probe_start = 1'b1;
            state_in        = S_CHECK;
         end

         S_CHECK: begin
            cmd.rd_sel_next = 1'b1;
            cmd.res_set     = 1'b1;
            state_in        = S_DONE;
            unique case (code)
               REQ_INS_HOME: begin
                  if (sts.key_nz && sts.slot_empty) begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_key     = 1'b1;
                     cmd.res_status = ST_OK;
                  end
               end
               REQ_INS_LINEAR, REQ_INS_QUAD: begin
                  if (!sts.key_nz) begin
                     cmd.res_status = ST_MISS;
                  end else if (sts.slot_empty) begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_key      = 1'b1;
                     cmd.res_use_idx = 1'b1;
                     cmd.res_status  = ST_OK;
                  end else if (sts.probe_last) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     // next candidate, read already issued
                     cmd.res_set   = 1'b0;
                     cmd.probe_adv = 1'b1;
                     state_in      = S_CHECK;
                  end
               end
               REQ_SEARCH: begin
                  if (sts.key_nz && sts.slot_match) begin
                     cmd.res_status = ST_OK;
                  end
               end
               REQ_DELETE: begin
                  if (sts.key_nz && sts.slot_match) begin
                     cmd.wr_en      = 1'b1;
                     cmd.res_status = ST_OK;
                  end
               end
               default: begin
                  cmd.res_status = ST_MISS;
               end
            endcase
         end

         S_DONE: begin
            // wait for the response register to free up
            if (!sts.rsp_blocked) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

@@ hdl/mhte_dp.sv @@
`timescale 1ns / 1ps

module mhte_dp #(
   parameter int TABLE_SIZE = 101
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mhte_pkg::cmd_type               cmd,
   output mhte_pkg::sts_type               sts,
   input  logic [mhte_pkg::REQ_W-1:0]      req_type,
   input  logic [mhte_pkg::KEY_W-1:0]      req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mhte_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mhte_pkg::SLOT_W-1:0]     rsp_slot
);

   import mhte_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   // quotient bits: floor(key / TABLE_SIZE) < 2^(KEY_W+1-IW)
   localparam int QW = KEY_W + 1 - IW;
   localparam logic [IW:0]   SIZE_W   = (IW+1)'(TABLE_SIZE);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
   localparam logic [KEY_W-1:0] SIZE_K = KEY_W'(TABLE_SIZE);
   // reciprocal floor(2^(KEY_W+IW) / TABLE_SIZE) + 1, exact for every key
   localparam logic [KEY_W:0] RECIP =
      (KEY_W+1)'(((64'd1 << (KEY_W + IW)) / 64'(TABLE_SIZE)) + 64'd1);

   logic [REQ_W-1:0]  req_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              phase_ff;
   logic [QW-1:0]     quot_ff;
   logic [IW-1:0]     rem_ff;
   logic [IW-1:0]     idx_ff;
   logic [IW-1:0]     step_ff;
   logic [IW-1:0]     cnt_ff;
   status_type        res_status_ff;
   logic [IW-1:0]     res_slot_ff;
   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic [2*KEY_W:0]  recip_prod;
   logic [QW-1:0]     quot_in;
   logic [KEY_W-1:0]  quot_back;
   logic [KEY_W-1:0]  rem_full;
   logic [IW-1:0]     rem_in;
   logic [IW:0]       idx_sum;
   logic [IW-1:0]     idx_in;
   logic [IW:0]       step_sum;
   logic [IW-1:0]     step_in;
   logic [SLOT_W+IW-1:0] slot_wide;
   logic [KEY_W-1:0]  rd_data;
   logic [KEY_W-1:0]  wr_data;
   logic [IW-1:0]     rd_addr;

   // key mod table size: reciprocal multiply for the quotient,
   // then multiply back and subtract on the next cycle
   assign recip_prod = (2*KEY_W+1)'(key_ff) * (2*KEY_W+1)'(RECIP);
   assign quot_in    = recip_prod[2*KEY_W -: QW];
   assign quot_back  = KEY_W'(quot_ff) * SIZE_K;
   assign rem_full   = key_ff - quot_back;
   assign rem_in     = rem_full[IW-1:0];

   // next probe slot: idx + step, wrapped
   assign idx_sum = {1'b0, idx_ff} + {1'b0, step_ff};
   assign idx_in  = (idx_sum >= SIZE_W) ? IW'(idx_sum - SIZE_W) : idx_sum[IW-1:0];

   // quadratic step grows by two per candidate: (i+1)^2 - i^2 = 2i + 1
   assign step_sum = {1'b0, step_ff} + (IW+1)'(2);
   assign step_in  = (step_sum >= SIZE_W) ? IW'(step_sum - SIZE_W) : step_sum[IW-1:0];

   // request capture and home slot reduction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_type;
         key_ff   <= req_key;
         phase_ff <= 1'b0;
         rem_ff   <= '0;
      end else if (cmd.mod_step) begin
         if (!phase_ff) begin
            quot_ff <= quot_in;
         end else begin
            rem_ff <= rem_in;
         end
         phase_ff <= 1'b1;
      end
   end

   // probe position, also walks the table for the clear pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         step_ff <= IW'(1);
         cnt_ff  <= '0;
      end else if (cmd.probe_start) begin
         idx_ff  <= rem_ff;
         step_ff <= IW'(1);
         cnt_ff  <= '0;
      end else if (cmd.probe_adv) begin
         idx_ff <= idx_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (req_ff == REQ_INS_QUAD) begin
            step_ff <= step_in;
         end
      end else if (cmd.clear_step) begin
         idx_ff <= idx_in;
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= cmd.res_use_idx ? idx_ff : rem_ff;
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, res_slot_ff};

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= slot_wide[SLOT_W-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   // key slot memory
   assign wr_data = cmd.wr_key ? key_ff : '0;
   assign rd_addr = cmd.rd_sel_next ? idx_in : rem_ff;

   mhte_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status to the controller
   always_comb begin
      sts.mod_last    = phase_ff;
      sts.key_nz      = (key_ff != '0);
      sts.slot_empty  = (rd_data == '0);
      sts.slot_match  = (rd_data == key_ff);
      sts.probe_last  = (cnt_ff == LAST_IDX);
      sts.clear_last  = (idx_ff == LAST_IDX);
      sts.rsp_blocked = rsp_valid_ff && rsp_stall;
      sts.req_code    = req_ff;
   end

endmodule

@@ hdl/mhte_checker.sv @@
`timescale 1ns / 1ps

module mhte_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mhte_pkg::STATUS_W-1:0] rsp_status
);

   import mhte_pkg::*;

   // reset starts the clear pass with nothing pending
   a_reset: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("req_stall low or rsp_valid high after reset");

   // one request at a time: an accepted beat closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   // a stalled response beat is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response dropped or changed");

   // status code is one of the three defined ones
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_MISS ||
                    rsp_status == ST_FULL)
      else $error("undefined response status");

endmodule

bind modulo_hash_table_engine_top mhte_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status)
);
